>>> src/rrc_pkg.sv
// Shared types, codes and constants of the rectangle raster canvas.
`default_nettype none
package rrc_pkg;

  // Default canvas geometry and fixed-point format
  localparam int unsigned MAX_COLS_DEF  = 256;
  localparam int unsigned MAX_ROWS_DEF  = 256;
  localparam int unsigned FRAC_BITS_DEF = 8;

  // Field widths
  localparam int unsigned FIX_W      = 20;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned RD_IDX_W   = 8;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Bound arithmetic width: x + w of two 20-bit values plus rounding headroom
  localparam int unsigned EXT_W = FIX_W + 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND    = 2'd2;

  // Register reset values
  localparam logic [SIZE_W-1:0] CANVAS_WIDTH_RST  = 9'd256;
  localparam logic [SIZE_W-1:0] CANVAS_HEIGHT_RST = 9'd256;
  localparam logic [CHAR_W-1:0] BACKGROUND_RST    = 8'd32;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_FILL    = 2'd1,
    CMD_OUTLINE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SIZE  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_SCAN,
    S_READ,
    S_DONE
  } fsm_t;

  // Request payload
  typedef struct packed {
    cmd_t                     cmd;
    logic signed [FIX_W-1:0]  x_pos;
    logic signed [FIX_W-1:0]  y_pos;
    logic signed [FIX_W-1:0]  rect_width;
    logic signed [FIX_W-1:0]  rect_height;
    logic [CHAR_W-1:0]        fill_char;
    logic [RD_IDX_W-1:0]      read_col;
    logic [RD_IDX_W-1:0]      read_row;
  } in_item_t;

  // Result payload
  typedef struct packed {
    status_t           status;
    logic [CHAR_W-1:0] pixel_char;
  } out_item_t;

  // Rectangle bounds and the clipped scan window handed to the scanner
  typedef struct packed {
    logic signed [EXT_W-1:0] left;
    logic signed [EXT_W-1:0] right;
    logic signed [EXT_W-1:0] top;
    logic signed [EXT_W-1:0] bottom;
    logic signed [EXT_W-1:0] c0;
    logic signed [EXT_W-1:0] c1;
    logic signed [EXT_W-1:0] r0;
    logic signed [EXT_W-1:0] r1;
    logic                    outline;
    logic                    size_bad;
    logic                    empty;
  } bnd_t;

endpackage
`default_nettype wire

>>> src/rrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/rrc_bounds.sv
// Integer bounds of a rectangle from its Q-format corner and size, clipped to the canvas.
`default_nettype none
module rrc_bounds #(
  parameter int unsigned FRAC_BITS = rrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire rrc_pkg::in_item_t                    item,
  input  wire logic signed [rrc_pkg::EXT_W-1:0]     cols_lim,
  input  wire logic signed [rrc_pkg::EXT_W-1:0]     rows_lim,
  output rrc_pkg::bnd_t                             bnd
);
  import rrc_pkg::*;

  localparam logic signed [EXT_W-1:0] RND = EXT_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [EXT_W-1:0] ZERO = '0;
  localparam logic signed [EXT_W-1:0] ONE  = EXT_W'(1);

  logic signed [EXT_W-1:0] x_e, y_e, w_e, h_e;
  logic signed [EXT_W-1:0] left, right, top, bottom;
  logic signed [EXT_W-1:0] c0, c1, r0, r1;
  logic                    size_bad;

  // Sign-extend the fixed-point fields
  assign x_e = EXT_W'(item.x_pos);
  assign y_e = EXT_W'(item.y_pos);
  assign w_e = EXT_W'(item.rect_width);
  assign h_e = EXT_W'(item.rect_height);

  // ceil for the near edges, floor (toward minus infinity) for the far edges
  assign left   = (x_e + RND) >>> FRAC_BITS;
  assign top    = (y_e + RND) >>> FRAC_BITS;
  assign right  = (x_e + w_e) >>> FRAC_BITS;
  assign bottom = (y_e + h_e) >>> FRAC_BITS;

  // Clip to the canvas in use
  assign c0 = (left < ZERO) ? ZERO : left;
  assign r0 = (top  < ZERO) ? ZERO : top;
  assign c1 = (right  > cols_lim - ONE) ? cols_lim - ONE : right;
  assign r1 = (bottom > rows_lim - ONE) ? rows_lim - ONE : bottom;

  // Width or height zero or negative
  assign size_bad = item.rect_width[FIX_W-1]  || (item.rect_width  == '0) ||
                    item.rect_height[FIX_W-1] || (item.rect_height == '0);

  // Bounds register
  always_ff @(posedge clk) begin
    if (en) begin
      bnd.left     <= left;
      bnd.right    <= right;
      bnd.top      <= top;
      bnd.bottom   <= bottom;
      bnd.c0       <= c0;
      bnd.c1       <= c1;
      bnd.r0       <= r0;
      bnd.r1       <= r1;
      bnd.outline  <= (item.cmd == CMD_OUTLINE);
      bnd.size_bad <= size_bad;
      bnd.empty    <= (c0 > c1) || (r0 > r1);
    end
  end

endmodule
`default_nettype wire

>>> src/rrc_scan.sv
// Pixel scanner: walks a clipped window one pixel per cycle and emits write strobes.
`default_nettype none
module rrc_scan #(
  parameter int unsigned MAX_COLS = rrc_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = rrc_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                             clk,
  input  wire logic                                             rst_n,
  input  wire logic                                             start,
  input  wire rrc_pkg::bnd_t                                    win,
  output logic                                                  wr_en,
  output logic [(MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0]      wr_col,
  output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)-1:0]      wr_row,
  output logic                                                  last
);
  import rrc_pkg::*;

  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  bnd_t             win_r;
  logic             busy_r, busy_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             col_end, row_end, on_edge;
  logic signed [EXT_W-1:0] col_e, row_e;

  assign col_e   = signed'(EXT_W'(col_r));
  assign row_e   = signed'(EXT_W'(row_r));
  assign col_end = (col_r == win_r.c1[COL_W-1:0]);
  assign row_end = (row_r == win_r.r1[ROW_W-1:0]);

  // Outline pixels sit on a bound row or column
  assign on_edge = (col_e == win_r.left) || (col_e == win_r.right) ||
                   (row_e == win_r.top)  || (row_e == win_r.bottom);

  assign wr_en  = busy_r && (!win_r.outline || on_edge);
  assign wr_col = col_r;
  assign wr_row = row_r;
  assign last   = busy_r && col_end && row_end;

  // Raster stepping, column fastest
  always_comb begin
    busy_nxt = busy_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (start) begin
      busy_nxt = 1'b1;
      col_nxt  = win.c0[COL_W-1:0];
      row_nxt  = win.r0[ROW_W-1:0];
    end else if (busy_r) begin
      if (col_end) begin
        col_nxt = win_r.c0[COL_W-1:0];
        if (row_end) begin
          busy_nxt = 1'b0;
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Position and window need no reset
  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    row_r <= row_nxt;
    if (start) begin
      win_r <= win;
    end
  end

endmodule
`default_nettype wire

>>> src/rectangle_raster_canvas_unit.sv
// Top level of the rectangle raster canvas: command sequencer, config registers, canvas RAM.
//
//  channel  | ports                               | moves
//  ---------+-------------------------------------+-------------------------------
//  request  | in_valid, in_stall, in_data         | one command (in_item_t)
//  result   | out_valid, out_stall, out_data      | status and pixel (out_item_t)
//  config   | cfg_we, cfg_idx, cfg_wdata          | register write, no read-back
//
// A clear writes all MAX_COLS*MAX_ROWS cells of the store, one RAM write per cycle.
// A draw passes S_PREP and S_CHECK and then scans every pixel of the clipped box, outline
// interior included, unless the size is bad or the box empty; RAM read data is registered.
// in_stall is high while a request is in work; one finished result waits in the output
// register, and a new request is taken while it waits. Reset is synchronous; the canvas
// RAM is not cleared by reset and holds undefined data until a clear or draw writes it.
`default_nettype none
module rectangle_raster_canvas_unit #(
  parameter int unsigned MAX_COLS  = rrc_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS  = rrc_pkg::MAX_ROWS_DEF,
  parameter int unsigned FRAC_BITS = rrc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire rrc_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output rrc_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [rrc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [rrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rrc_pkg::*;

  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ADDR_W = COL_W + ROW_W;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;
  localparam logic signed [EXT_W-1:0] MAXC_E = EXT_W'(MAX_COLS);
  localparam logic signed [EXT_W-1:0] MAXR_E = EXT_W'(MAX_ROWS);

  // Configuration registers
  logic [SIZE_W-1:0] canvas_width_r;
  logic [SIZE_W-1:0] canvas_height_r;
  logic [CHAR_W-1:0] background_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= CANVAS_WIDTH_RST;
      canvas_height_r <= CANVAS_HEIGHT_RST;
      background_r    <= BACKGROUND_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CANVAS_WIDTH:  canvas_width_r  <= cfg_wdata[SIZE_W-1:0];
        REG_CANVAS_HEIGHT: canvas_height_r <= cfg_wdata[SIZE_W-1:0];
        REG_BACKGROUND:    background_r    <= cfg_wdata[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Size in use, limited to the store
  logic signed [EXT_W-1:0] cw_e, ch_e, cols_lim, rows_lim;
  assign cw_e     = signed'(EXT_W'(canvas_width_r));
  assign ch_e     = signed'(EXT_W'(canvas_height_r));
  assign cols_lim = (cw_e > MAXC_E) ? MAXC_E : cw_e;
  assign rows_lim = (ch_e > MAXR_E) ? MAXR_E : ch_e;

  // Sequencer state and held request
  fsm_t      state_r, state_nxt;
  in_item_t  item_r;
  status_t   stat_r, stat_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;
  logic      in_acc, out_acc, out_load;
  logic      scan_start, scan_last;
  bnd_t      bnd, clr_win, scan_win;
  logic      clear_mode;

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Bounds unit
  rrc_bounds #(
    .FRAC_BITS (FRAC_BITS)
  ) u_bounds (
    .clk      (clk),
    .en       (state_r == S_PREP),
    .item     (item_r),
    .cols_lim (cols_lim),
    .rows_lim (rows_lim),
    .bnd      (bnd)
  );

  // Clear sweeps the whole store
  always_comb begin
    clr_win          = '0;
    clr_win.c1       = EXT_W'(MAX_COLS - 1);
    clr_win.r1       = EXT_W'(MAX_ROWS - 1);
  end

  assign clear_mode = (state_r == S_IDLE);
  assign scan_win   = clear_mode ? clr_win : bnd;

  // Pixel scanner
  logic             wr_en;
  logic [COL_W-1:0] wr_col;
  logic [ROW_W-1:0] wr_row;

  rrc_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scan_start),
    .win    (scan_win),
    .wr_en  (wr_en),
    .wr_col (wr_col),
    .wr_row (wr_row),
    .last   (scan_last)
  );

  // Canvas store
  logic signed [EXT_W-1:0] rd_col_e, rd_row_e;
  logic [ADDR_W-1:0]       raddr;
  logic [CHAR_W-1:0]       wdata, rdata;

  assign rd_col_e = signed'(EXT_W'(item_r.read_col));
  assign rd_row_e = signed'(EXT_W'(item_r.read_row));
  assign raddr    = {rd_row_e[ROW_W-1:0], rd_col_e[COL_W-1:0]};
  assign wdata    = (item_r.cmd == CMD_CLEAR) ? background_r : item_r.fill_char;

  rrc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (wr_en),
    .waddr ({wr_row, wr_col}),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Next state and control
  always_comb begin
    state_nxt  = state_r;
    stat_nxt   = stat_r;
    scan_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          stat_nxt = STAT_OK;
          case (in_data.cmd)
            CMD_CLEAR: begin
              scan_start = 1'b1;
              state_nxt  = S_SCAN;
            end
            CMD_READ: state_nxt = S_READ;
            default:  state_nxt = S_PREP;
          endcase
        end
      end
      S_PREP: state_nxt = S_CHECK;
      S_CHECK: begin
        if (bnd.size_bad) begin
          stat_nxt  = STAT_SIZE;
          state_nxt = S_DONE;
        end else if (bnd.empty) begin
          state_nxt = S_DONE;
        end else begin
          scan_start = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        if (rd_col_e >= cols_lim || rd_row_e >= rows_lim) begin
          stat_nxt = STAT_RANGE;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_acc) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    if (in_acc) begin
      item_r <= in_data;
    end
    if (out_load) begin
      out_data_r.status     <= stat_r;
      out_data_r.pixel_char <= (item_r.cmd == CMD_READ && stat_r == STAT_OK) ? rdata : '0;
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/rrc_canvas_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the rectangle raster canvas: keeps a shadow canvas and checks every result.
module rrc_canvas_checker
  import rrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           outstanding,
  output int unsigned           results_checked
);

  localparam int ONE_Q = 1 << FRAC_BITS_DEF;

  // Shadow of the canvas store and of the three registers
  logic [CHAR_W-1:0] shadow_canvas [MAX_COLS_DEF * MAX_ROWS_DEF];
  logic [SIZE_W-1:0] shadow_cols;
  logic [SIZE_W-1:0] shadow_rows;
  logic [CHAR_W-1:0] shadow_bg;

  // Status and pixel expected for each request taken, oldest first
  out_item_t awaited_results [$];

  // Arithmetic shift on a signed int rounds toward minus infinity
  function automatic int floor_q(int v);
    return v >>> FRAC_BITS_DEF;
  endfunction

  function automatic int ceil_q(int v);
    return floor_q(v + ONE_Q - 1);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $time, results_checked, msg);
    mismatches++;
  endtask

  // Apply one command to the shadow canvas and work out its result
  task automatic run_canvas_command(input in_item_t req, output out_item_t res);
    int cols, rows, x, y, w, h;
    int b_left, b_right, b_top, b_bottom, c0, c1, r0, r1;
    res.status     = STAT_OK;
    res.pixel_char = '0;
    cols = (shadow_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : shadow_cols;
    rows = (shadow_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : shadow_rows;
    case (req.cmd)
      CMD_CLEAR: begin
        // clear covers the whole store, not just the part in use
        foreach (shadow_canvas[i]) shadow_canvas[i] = shadow_bg;
      end
      CMD_READ: begin
        if (int'(req.read_col) >= cols || int'(req.read_row) >= rows)
          res.status = STAT_RANGE;
        else
          res.pixel_char = shadow_canvas[int'(req.read_row) * MAX_COLS_DEF +
                                         int'(req.read_col)];
      end
      default: begin
        x = $signed(req.x_pos);
        y = $signed(req.y_pos);
        w = $signed(req.rect_width);
        h = $signed(req.rect_height);
        if (w <= 0 || h <= 0) begin
          res.status = STAT_SIZE;
        end else begin
          b_left   = ceil_q(x);
          b_top    = ceil_q(y);
          b_right  = floor_q(x + w);
          b_bottom = floor_q(y + h);
          // clip to the canvas in use
          c0 = (b_left < 0) ? 0 : b_left;
          r0 = (b_top < 0) ? 0 : b_top;
          c1 = (b_right > cols - 1) ? cols - 1 : b_right;
          r1 = (b_bottom > rows - 1) ? rows - 1 : b_bottom;
          for (int r = r0; r <= r1; r++) begin
            for (int c = c0; c <= c1; c++) begin
              // outline keeps only the bound rows and columns
              if (req.cmd == CMD_FILL || c == b_left || c == b_right ||
                  r == b_top || r == b_bottom)
                shadow_canvas[r * MAX_COLS_DEF + c] = req.fill_char;
            end
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t predicted;
    if (!rst_n) begin
      shadow_cols = CANVAS_WIDTH_RST;
      shadow_rows = CANVAS_HEIGHT_RST;
      shadow_bg   = BACKGROUND_RST;
      awaited_results.delete();
      outstanding <= 0;
    end else begin
      // the user makes register writes only while the block is idle; the block does not enforce it
      if (cfg_we) begin
        case (cfg_idx)
          REG_CANVAS_WIDTH:  shadow_cols = cfg_wdata;
          REG_CANVAS_HEIGHT: shadow_rows = cfg_wdata;
          REG_BACKGROUND:    shadow_bg   = cfg_wdata[CHAR_W-1:0];
          default: ;
        endcase
      end
      // results first, so a result can never match a request taken on the same edge
      if (out_valid && !out_stall) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting (status %0d, pixel %0d)",
                                    out_data.status, out_data.pixel_char));
        end else begin
          want = awaited_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.pixel_char !== want.pixel_char)
            report_mismatch($sformatf("pixel_char got %0d, expected %0d",
                                      out_data.pixel_char, want.pixel_char));
        end
      end
      if (in_valid && !in_stall) begin
        run_canvas_command(in_data, predicted);
        awaited_results.push_back(predicted);
      end
      outstanding <= awaited_results.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench top: clock, reset, request and register stimulus for the canvas unit, verdict.
module tb;
  import rrc_pkg::*;

  localparam int          ONE_Q          = 1 << FRAC_BITS_DEF;
  // allow well over the length of a full clear with no transfer
  localparam int unsigned WATCHDOG_LIMIT = 300000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // no idling on either side when set
  logic        calm          = 1'b0;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned requests_sent = 0;
  int unsigned settings_run  = 1;
  int unsigned cur_cols      = 256;
  int unsigned cur_rows      = 256;
  int unsigned stall_left    = 0;
  int unsigned idle_cycles   = 0;

  always #5 clk = ~clk;

  rectangle_raster_canvas_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  rrc_canvas_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  // Result side stalls in random bursts
  always @(posedge clk) begin
    if (calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: ends the run if nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Every field random; callers overwrite what the command uses
  function automatic in_item_t scrambled_request();
    in_item_t r;
    r.cmd         = cmd_t'($urandom_range(0, 3));
    r.x_pos       = FIX_W'($urandom_range(0, 20'hFFFFF));
    r.y_pos       = FIX_W'($urandom_range(0, 20'hFFFFF));
    r.rect_width  = FIX_W'($urandom_range(0, 20'hFFFFF));
    r.rect_height = FIX_W'($urandom_range(0, 20'hFFFFF));
    r.fill_char   = CHAR_W'($urandom_range(0, 255));
    r.read_col    = RD_IDX_W'($urandom_range(0, 255));
    r.read_row    = RD_IDX_W'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic in_item_t clear_request();
    in_item_t r = scrambled_request();
    r.cmd = CMD_CLEAR;
    return r;
  endfunction

  function automatic in_item_t read_request(int col, int row);
    in_item_t r = scrambled_request();
    r.cmd      = CMD_READ;
    r.read_col = col[RD_IDX_W-1:0];
    r.read_row = row[RD_IDX_W-1:0];
    return r;
  endfunction

  // Geometry in Q11.8 units
  function automatic in_item_t rect_request(cmd_t op, int x, int y, int w, int h, int ch);
    in_item_t r = scrambled_request();
    r.cmd         = op;
    r.x_pos       = x[FIX_W-1:0];
    r.y_pos       = y[FIX_W-1:0];
    r.rect_width  = w[FIX_W-1:0];
    r.rect_height = h[FIX_W-1:0];
    r.fill_char   = ch[CHAR_W-1:0];
    return r;
  endfunction

  // Mostly boxes on or near the canvas in use, some reads, some bad sizes and noise
  function automatic in_item_t random_request();
    in_item_t r;
    int cols_u, rows_u, pick, max_w, max_h;
    r      = scrambled_request();
    cols_u = (cur_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : cur_cols;
    rows_u = (cur_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : cur_rows;
    max_w  = (cols_u <= 32) ? cols_u + 4 : 24;
    max_h  = (rows_u <= 32) ? rows_u + 4 : 24;
    pick   = $urandom_range(0, 99);
    if (pick < 60) begin
      r = rect_request((pick < 36) ? CMD_FILL : CMD_OUTLINE,
                       (int'($urandom_range(0, cols_u + 6)) - 4) * ONE_Q +
                         int'($urandom_range(0, ONE_Q - 1)),
                       (int'($urandom_range(0, rows_u + 6)) - 4) * ONE_Q +
                         int'($urandom_range(0, ONE_Q - 1)),
                       int'($urandom_range(1, max_w * ONE_Q)),
                       int'($urandom_range(1, max_h * ONE_Q)),
                       $urandom_range(0, 255));
    end else if (pick < 88) begin
      r.cmd = CMD_READ;
      // a few reads keep their full random position
      if (pick < 84) begin
        r.read_col = RD_IDX_W'($urandom_range(0, (cols_u + 2 > 255) ? 255 : cols_u + 2));
        r.read_row = RD_IDX_W'($urandom_range(0, (rows_u + 2 > 255) ? 255 : rows_u + 2));
      end
    end else if (pick < 94) begin
      r.cmd = pick[0] ? CMD_FILL : CMD_OUTLINE;
      if ($urandom_range(0, 1))
        r.rect_width = FIX_W'(-int'($urandom_range(0, 524288)));
      else
        r.rect_height = FIX_W'(-int'($urandom_range(0, 524288)));
    end else if (cols_u * rows_u <= 4096) begin
      // full random geometry, cheap only on a small canvas
      r.cmd = pick[0] ? CMD_FILL : CMD_OUTLINE;
    end else begin
      r.cmd = CMD_READ;
    end
    return r;
  endfunction

  // Hold the request until it is taken; valid stays high into the next request
  task automatic send_request(input in_item_t req);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // New canvas setting once the block is idle, then random traffic
  task automatic run_phase(input int unsigned cols, rows, bg, input bit with_clear,
                           input int unsigned count);
    drain_results();
    write_reg(REG_CANVAS_WIDTH, cols);
    write_reg(REG_CANVAS_HEIGHT, rows);
    write_reg(REG_BACKGROUND, bg);
    cfg_we   <= 1'b0;
    cur_cols = cols;
    cur_rows = rows;
    settings_run++;
    if (with_clear) send_request(clear_request());
    repeat (count) send_request(random_request());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset setting; clear first so no read sees unwritten pixels
    send_request(clear_request());
    send_request(read_request(0, 0));
    send_request(read_request(255, 255));
    // fractional corners: cols 2..4, rows 3..4
    send_request(rect_request(CMD_FILL, 384, 576, 768, 640, 8'hFF));
    send_request(read_request(2, 3));
    send_request(read_request(4, 4));
    send_request(read_request(1, 3));
    send_request(rect_request(CMD_OUTLINE, 10 * ONE_Q, 10 * ONE_Q, 5 * ONE_Q, 5 * ONE_Q, 0));
    send_request(read_request(12, 12));
    send_request(read_request(15, 12));
    // sizes that are not positive
    send_request(rect_request(CMD_FILL, 0, 0, 0, ONE_Q, 1));
    send_request(rect_request(CMD_OUTLINE, 0, 0, ONE_Q, -1, 2));
    send_request(rect_request(CMD_FILL, 0, 0, -524288, 524287, 3));
    // right bound below left bound: nothing drawn
    send_request(rect_request(CMD_FILL, 128, 0, 64, 4 * ONE_Q, 3));
    // negative corner, y + h = -0.75 must floor to -1
    send_request(rect_request(CMD_FILL, -1408, -832, 1472, 640, 4));
    send_request(read_request(0, 0));
    // y + h = 0.5 reaches row 0
    send_request(rect_request(CMD_FILL, -1408, -384, 1472, 512, 5));
    send_request(read_request(0, 0));
    // field extremes, both far off the canvas
    send_request(rect_request(CMD_FILL, -524288, -524288, 524287, 524287, 6));
    send_request(rect_request(CMD_OUTLINE, 524287, 524287, 524287, 524287, 7));
    // outline around the whole canvas
    send_request(rect_request(CMD_OUTLINE, 0, 0, 255 * ONE_Q, 255 * ONE_Q, 8'h23));
    send_request(read_request(0, 128));
    send_request(read_request(128, 128));
    send_request(read_request(255, 255));

    // Random part over several settings, extremes among them
    run_phase(24, 16, 8'h2E, 1'b1, 18);
    run_phase(1, 1, 8'h00, 1'b1, 10);
    run_phase(0, 256, 8'hFF, 1'b0, 8);
    run_phase(5, 0, 8'h41, 1'b0, 6);
    run_phase(511, 7, "R", 1'b1, 18);
    calm <= 1'b1;
    run_phase(256, 256, "r", 1'b1, 24);

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d requests and %0d results over %0d canvas settings.",
             requests_sent, results_checked, settings_run);
    $display("Clears, fills, outlines, reads, bad sizes, empty and clipped boxes all exercised.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
